// ===== rtl/arwt_pkg.sv =====
// Shared types, constants and command/status records for the address range watch table.
package arwt_pkg;

  // Table geometry
  localparam int NUM_SLOTS     = 32;
  localparam int PAGE_NUM_BITS = 36;
  localparam int END_BITS      = PAGE_NUM_BITS + 1;
  localparam int MODE_BITS     = 2;
  localparam int SLOT_IDX_W    = $clog2(NUM_SLOTS);

  // Stream packing: start, end, mode, page from bit 0 up
  localparam int IN_END_LSB    = PAGE_NUM_BITS;
  localparam int IN_MODE_LSB   = IN_END_LSB + END_BITS;
  localparam int IN_PAGE_LSB   = IN_MODE_LSB + MODE_BITS;
  localparam int IN_FIELD_BITS = IN_PAGE_LSB + PAGE_NUM_BITS;
  localparam int IN_TDATA_W    = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OP_BITS       = 2;

  // Result packing: status, hit, hit_mode from bit 0 up
  localparam int OUT_FIELD_BITS = 2 + 1 + MODE_BITS;
  localparam int OUT_TDATA_W    = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef logic [PAGE_NUM_BITS-1:0] page_t;
  typedef logic [END_BITS-1:0]      end_t;
  typedef logic [MODE_BITS-1:0]     mode_t;
  typedef logic [SLOT_IDX_W-1:0]    slot_idx_t;

  typedef enum logic [OP_BITS-1:0] {
    OP_REGISTER   = 2'd0,
    OP_UNREGISTER = 2'd1,
    OP_LOOKUP     = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_NOENT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_SCAN,
    S_DONE
  } state_t;

  // Table write kinds
  typedef enum logic [2:0] {
    WR_NONE,
    WR_MODE,       // slot k: replace mode
    WR_HEAD,       // slot k: start moves to request end
    WR_TRIM,       // slot k: end moves to request start
    WR_FREE,       // slot k: drop
    WR_FILL_REG,   // slot j: new range from request
    WR_FILL_TAIL   // slot j: tail of split slot k
  } wr_kind_t;

  // Result kinds latched into the pending result
  typedef enum logic [2:0] {
    RES_NONE,
    RES_ZERO,
    RES_OK,
    RES_FULL,
    RES_UNREG,
    RES_HIT,
    RES_MISS
  } res_kind_t;

  typedef struct packed {
    page_t start;
    end_t  stop;
    mode_t mode;
  } entry_t;

  typedef struct packed {
    op_t   op;
    page_t start;
    end_t  stop;
    mode_t mode;
    page_t page;
  } item_t;

  typedef struct packed {
    status_t status;
    logic    hit;
    mode_t   hit_mode;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic      load;
    logic      rd;
    logic      inc_k;
    logic      clr_j;
    logic      inc_j;
    logic      set_any;
    wr_kind_t  wr;
    res_kind_t res;
    logic      out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic exact;
    logic overlap;
    logic cover_all;
    logic cover_head;
    logic cover_tail;
    logic hole;
    logic covers_page;
    logic k_last;
    logic j_free;
    logic j_last;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/arwt_ctrl.sv =====
// Sequencing state machine for the slot walk and free-slot scan.
module arwt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  arwt_pkg::stat_t stat,
  output arwt_pkg::cmd_t  cmd
);
  import arwt_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        unique case (stat.op)
          OP_REGISTER: begin
            if (stat.exact) state_next = S_DONE;
            else if (stat.k_last) state_next = S_SCAN;
            else state_next = S_READ;
          end
          OP_UNREGISTER: begin
            if (stat.hole) state_next = S_SCAN;
            else if (stat.k_last) state_next = S_DONE;
            else state_next = S_READ;
          end
          OP_LOOKUP: begin
            if (stat.covers_page || stat.k_last) state_next = S_DONE;
            else state_next = S_READ;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_SCAN: begin
        unique case (stat.op)
          OP_REGISTER: begin
            if (stat.j_free || stat.j_last) state_next = S_DONE;
          end
          OP_UNREGISTER: begin
            if (stat.j_free || stat.j_last) begin
              state_next = stat.k_last ? S_DONE : S_READ;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_DONE: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_READ: begin
        cmd.rd = 1'b1;
      end
      S_EVAL: begin
        unique case (stat.op)
          OP_REGISTER: begin
            if (stat.exact) begin
              cmd.wr  = WR_MODE;
              cmd.res = RES_OK;
            end else if (stat.k_last) begin
              cmd.clr_j = 1'b1;
            end else begin
              cmd.inc_k = 1'b1;
            end
          end
          OP_UNREGISTER: begin
            cmd.set_any = stat.overlap;
            if (stat.cover_all) cmd.wr = WR_FREE;
            else if (stat.cover_head) cmd.wr = WR_HEAD;
            else if (stat.cover_tail || stat.hole) cmd.wr = WR_TRIM;
            if (stat.hole) cmd.clr_j = 1'b1;
            else if (stat.k_last) cmd.res = RES_UNREG;
            else cmd.inc_k = 1'b1;
          end
          OP_LOOKUP: begin
            if (stat.covers_page) cmd.res = RES_HIT;
            else if (stat.k_last) cmd.res = RES_MISS;
            else cmd.inc_k = 1'b1;
          end
          default: cmd.res = RES_ZERO;
        endcase
      end
      S_SCAN: begin
        unique case (stat.op)
          OP_REGISTER: begin
            if (stat.j_free) begin
              cmd.wr  = WR_FILL_REG;
              cmd.res = RES_OK;
            end else if (stat.j_last) begin
              cmd.res = RES_FULL;
            end else begin
              cmd.inc_j = 1'b1;
            end
          end
          OP_UNREGISTER: begin
            // no free slot means the tail is dropped
            if (stat.j_free) cmd.wr = WR_FILL_TAIL;
            if (stat.j_free || stat.j_last) begin
              if (stat.k_last) cmd.res = RES_UNREG;
              else cmd.inc_k = 1'b1;
            end else begin
              cmd.inc_j = 1'b1;
            end
          end
          default: cmd.res = RES_ZERO;
        endcase
      end
      S_DONE: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  // Evaluation always follows a slot read
  assert property (@(posedge clk) disable iff (rst)
    state == S_EVAL |-> $past(state) == S_READ)
    else $error("arwt_ctrl: evaluation without a preceding read");
`endif

endmodule

// ===== rtl/arwt_dp.sv =====
// Slot table storage, range compares, walk counters and result registers.
module arwt_dp (
  input  logic               clk,
  input  logic               rst,
  input  arwt_pkg::item_t    in_item,
  input  arwt_pkg::cmd_t     cmd,
  output arwt_pkg::stat_t    stat,
  output logic               out_valid,
  input  logic               out_ready,
  output arwt_pkg::result_t  out_res
);
  import arwt_pkg::*;

  item_t     item;
  slot_idx_t k;
  slot_idx_t j;
  logic      any;
  logic      any_now;
  logic [NUM_SLOTS-1:0] slot_valid;
  entry_t    slot_mem [NUM_SLOTS];
  entry_t    rd_q;
  result_t   res_hold;

  logic      wr_en;
  slot_idx_t wr_addr;
  entry_t    wr_data;

  end_t rs_ext;
  end_t s_ext;
  end_t pg_ext;
  logic v_k;
  logic s_le_rs;
  logic e_ge_re;

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_item;
  end

  // Walk and scan counters, overlap flag
  always_ff @(posedge clk) begin
    if (rst) begin
      k   <= '0;
      j   <= '0;
      any <= 1'b0;
    end else begin
      if (cmd.load) k <= '0;
      else if (cmd.inc_k) k <= k + 1'b1;
      if (cmd.clr_j) j <= '0;
      else if (cmd.inc_j) j <= j + 1'b1;
      if (cmd.load) any <= 1'b0;
      else if (cmd.set_any) any <= 1'b1;
    end
  end

  // Write decode
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = k;
    wr_data = rd_q;
    case (cmd.wr)
      WR_MODE:      wr_data.mode = item.mode;
      WR_HEAD:      wr_data.start = item.stop[PAGE_NUM_BITS-1:0];
      WR_TRIM:      wr_data.stop = end_t'(item.start);
      WR_FILL_REG: begin
        wr_addr = j;
        wr_data = '{start: item.start, stop: item.stop, mode: item.mode};
      end
      WR_FILL_TAIL: begin
        wr_addr       = j;
        wr_data.start = item.stop[PAGE_NUM_BITS-1:0];
      end
      default:      wr_en = 1'b0;
    endcase
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (cmd.wr == WR_FREE) begin
      slot_valid[k] <= 1'b0;
    end else if (cmd.wr == WR_FILL_REG || cmd.wr == WR_FILL_TAIL) begin
      slot_valid[j] <= 1'b1;
    end
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) slot_mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) rd_q <= slot_mem[k];
  end

  // Range compares against the slot just read
  always_comb begin
    rs_ext  = end_t'(rd_q.start);
    s_ext   = end_t'(item.start);
    pg_ext  = end_t'(item.page);
    v_k     = slot_valid[k];
    s_le_rs = s_ext <= rs_ext;
    e_ge_re = item.stop >= rd_q.stop;

    stat.op          = item.op;
    stat.exact       = v_k && rd_q.start == item.start && rd_q.stop == item.stop;
    stat.overlap     = v_k && !(item.stop <= rs_ext || s_ext >= rd_q.stop);
    stat.cover_all   = stat.overlap && s_le_rs && e_ge_re;
    stat.cover_head  = stat.overlap && s_le_rs && !e_ge_re;
    stat.cover_tail  = stat.overlap && !s_le_rs && e_ge_re;
    stat.hole        = stat.overlap && !s_le_rs && !e_ge_re;
    stat.covers_page = v_k && pg_ext >= rs_ext && pg_ext < rd_q.stop;
    stat.k_last      = k == slot_idx_t'(NUM_SLOTS - 1);
    stat.j_free      = !slot_valid[j];
    stat.j_last      = j == slot_idx_t'(NUM_SLOTS - 1);
    stat.out_free    = !out_valid || out_ready;
  end

  assign any_now = any || cmd.set_any;

  // Pending result
  always_ff @(posedge clk) begin
    case (cmd.res)
      RES_ZERO:  res_hold <= '{status: ST_OK, hit: 1'b0, hit_mode: '0};
      RES_OK:    res_hold <= '{status: ST_OK, hit: 1'b0, hit_mode: '0};
      RES_FULL:  res_hold <= '{status: ST_FULL, hit: 1'b0, hit_mode: '0};
      RES_UNREG: res_hold <= '{status: (any_now ? ST_OK : ST_NOENT), hit: 1'b0,
                               hit_mode: '0};
      RES_HIT:   res_hold <= '{status: ST_OK, hit: |(rd_q.mode & item.mode),
                               hit_mode: rd_q.mode};
      RES_MISS:  res_hold <= '{status: ST_OK, hit: 1'b0, hit_mode: '0};
      default:   res_hold <= res_hold;
    endcase
  end

  // Output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_res <= res_hold;
  end

`ifndef SYNTHESIS
  // A new range or split tail only lands in a free slot
  assert property (@(posedge clk) disable iff (rst)
    (cmd.wr == WR_FILL_REG || cmd.wr == WR_FILL_TAIL) |-> !slot_valid[j])
    else $error("arwt_dp: fill into an occupied slot");

  // Edits to the walked slot only touch live entries
  assert property (@(posedge clk) disable iff (rst)
    (cmd.wr == WR_FREE || cmd.wr == WR_HEAD || cmd.wr == WR_TRIM ||
     cmd.wr == WR_MODE) |-> slot_valid[k])
    else $error("arwt_dp: edit of an empty slot");

  // A hit is only reported with ok status and a nonzero mode
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.hit) |-> (out_res.status == ST_OK && out_res.hit_mode != '0))
    else $error("arwt_dp: inconsistent hit result");
`endif

endmodule

// ===== rtl/address_range_watch_table.sv =====
// Top level of the address range watch table: stream ports, controller and datapath.
//
//  channel  | dir | tdata (low bit up)                          | tuser
//  s_axis   | in  | start_page, end_page, mode_bits, page, pad  | op
//  m_axis   | out | status, hit, hit_mode, pad                  | -
//
// One request at a time. Each slot visited passes a read state and a compare state; a
// lookup stops at the first slot that covers the page, an unregister walks every slot and
// scans for a free slot per split, a register walks until an exact match, else scans.
// Reset clears the valid bits at once; no clearing pass is needed after reset.
// The result sits in an output register; a stall on m_axis also blocks new requests.
module address_range_watch_table (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // start_page, end_page, mode_bits, page, zero pad
  input  logic [arwt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // op
  input  logic [arwt_pkg::OP_BITS-1:0]       s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // status, hit, hit_mode, zero pad
  output logic [arwt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import arwt_pkg::*;

  item_t   in_item;
  cmd_t    cmd;
  stat_t   stat;
  result_t out_res;

  // Unpack the request beat
  always_comb begin
    in_item.op    = op_t'(s_axis_tuser);
    in_item.start = s_axis_tdata[PAGE_NUM_BITS-1:0];
    in_item.stop  = s_axis_tdata[IN_END_LSB +: END_BITS];
    in_item.mode  = s_axis_tdata[IN_MODE_LSB +: MODE_BITS];
    in_item.page  = s_axis_tdata[IN_PAGE_LSB +: PAGE_NUM_BITS];
  end

  arwt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  arwt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  // Pack the result beat
  assign m_axis_tdata = OUT_TDATA_W'({out_res.hit_mode, out_res.hit, out_res.status});

endmodule

// ===== bench/arwt_check_pkg.sv =====
// Scoreboard class for the address range watch table testbench: slot table tracking and result checks.
`timescale 1ns / 1ps

package arwt_check_pkg;
  import arwt_pkg::*;

  class range_table_checker;
    // Shadow copy of the slot table
    logic    used [NUM_SLOTS];
    page_t   lo   [NUM_SLOTS];
    end_t    hi   [NUM_SLOTS];
    mode_t   md   [NUM_SLOTS];
    result_t expected_results [$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      for (int k = 0; k < NUM_SLOTS; k++) begin
        used[k] = 1'b0;
        lo[k]   = '0;
        hi[k]   = '0;
        md[k]   = '0;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Lowest unused slot, NUM_SLOTS when the table is full
    function int lowest_free();
      for (int k = 0; k < NUM_SLOTS; k++) begin
        if (!used[k]) return k;
      end
      return NUM_SLOTS;
    endfunction

    // Same range already present: only the mode changes
    function status_t add_range(page_t s, end_t e, mode_t m);
      int f;
      for (int k = 0; k < NUM_SLOTS; k++) begin
        if (used[k] && lo[k] == s && hi[k] == e) begin
          md[k] = m;
          return ST_OK;
        end
      end
      f = lowest_free();
      if (f == NUM_SLOTS) return ST_FULL;
      used[f] = 1'b1;
      lo[f]   = s;
      hi[f]   = e;
      md[f]   = m;
      return ST_OK;
    endfunction

    // Walk slots upward: drop, trim head, trim tail or split each overlapped range
    function status_t remove_range(page_t s, end_t e);
      logic any;
      int   f;
      any = 1'b0;
      for (int k = 0; k < NUM_SLOTS; k++) begin
        if (used[k] && !(e <= {1'b0, lo[k]} || {1'b0, s} >= hi[k])) begin
          any = 1'b1;
          if (s <= lo[k] && e >= hi[k]) begin
            used[k] = 1'b0;
          end else if (s <= lo[k]) begin
            lo[k] = e[PAGE_NUM_BITS-1:0];
          end else if (e >= hi[k]) begin
            hi[k] = {1'b0, s};
          end else begin
            // hole: tail goes to the lowest free slot, lost when none is free
            f = lowest_free();
            if (f < NUM_SLOTS) begin
              used[f] = 1'b1;
              lo[f]   = e[PAGE_NUM_BITS-1:0];
              hi[f]   = hi[k];
              md[f]   = md[k];
            end
            hi[k] = {1'b0, s};
          end
        end
      end
      return any ? ST_OK : ST_NOENT;
    endfunction

    // Accepted request beat: update the table and queue the expected result
    function void note_request(op_t op, page_t s, end_t e, mode_t m, page_t pg);
      result_t r;
      logic    found;
      r     = '0;
      found = 1'b0;
      case (op)
        OP_REGISTER:   r.status = add_range(s, e, m);
        OP_UNREGISTER: r.status = remove_range(s, e);
        OP_LOOKUP: begin
          r.status = ST_OK;
          for (int k = 0; k < NUM_SLOTS; k++) begin
            if (!found && used[k] && pg >= lo[k] && {1'b0, pg} < hi[k]) begin
              found      = 1'b1;
              r.hit_mode = md[k];
              r.hit      = |(md[k] & m);
            end
          end
        end
        default: ;
      endcase
      expected_results.push_back(r);
    endfunction

    // Result beat: tdata holds status [1:0], hit [2], hit_mode [4:3]
    function void check_result(logic [OUT_TDATA_W-1:0] d);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("result beat with no request outstanding, tdata=%h", d);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      if (d[1:0] != want.status) begin
        $error("status: expected %0d, got %0d", want.status, d[1:0]);
        mismatches++;
      end
      if (d[2] != want.hit) begin
        $error("hit: expected %0d, got %0d", want.hit, d[2]);
        mismatches++;
      end
      if (d[4:3] != want.hit_mode) begin
        $error("hit_mode: expected %0d, got %0d", want.hit_mode, d[4:3]);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ===== bench/address_range_watch_table_tb.sv =====
// Testbench top for the address range watch table: stimulus, stream drivers and end of run.
`timescale 1ns / 1ps

module address_range_watch_table_tb;
  import arwt_pkg::*;
  import arwt_check_pkg::*;

  localparam end_t  END_TOP     = {1'b1, {PAGE_NUM_BITS{1'b0}}};
  localparam page_t PAGE_TOP    = '1;
  localparam int    RAND_ITEMS  = 1000;
  localparam int    PHASE_LEN   = 100;
  localparam int    HOLD_AT     = 150;
  localparam int    HOLD_CYCLES = 600;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [OP_BITS-1:0]     s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  range_table_checker tracker = new();
  bit                 quiet   = 1'b0;
  int unsigned        results_seen = 0;

  always #1 clk = ~clk;

  address_range_watch_table DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Idle length: mostly none or short, now and then long
  function automatic int idle_cycles();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic page_t rand_page();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[PAGE_NUM_BITS-1:0];
  endfunction

  function automatic end_t rand_end();
    if ($urandom_range(0, 7) == 0) return END_TOP;
    return {1'b0, rand_page()};
  endfunction

  // Offer one request beat, called and returning at a falling edge
  task automatic send_item(input op_t op, input page_t s, input end_t e, input mode_t m,
                           input page_t pg);
    int                    gap;
    logic [IN_TDATA_W-1:0] d;
    gap = idle_cycles();
    d   = '0;
    d[IN_END_LSB-1:0]              = s;
    d[IN_MODE_LSB-1:IN_END_LSB]    = e;
    d[IN_PAGE_LSB-1:IN_MODE_LSB]   = m;
    d[IN_FIELD_BITS-1:IN_PAGE_LSB] = pg;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    tracker.note_request(op, s, e, m, pg);
    @(negedge clk);
  endtask

  // Result side: random stalls, one long hold-off while requests are still being offered
  initial begin
    int gap;
    while (rst) @(negedge clk);
    forever begin
      gap = (results_seen == HOLD_AT) ? HOLD_CYCLES : idle_cycles();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      tracker.check_result(m_axis_tdata);
      results_seen++;
      @(negedge clk);
    end
  end

  // Stimulus
  initial begin
    page_t base;
    page_t s;
    page_t pg;
    end_t  e;
    mode_t m;
    op_t   op;
    int    reg_pct;
    int    pick;
    int    shape;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, mode replace, extremes, degenerate ranges, split/trim/free
    send_item(OP_LOOKUP,     '0,       '0,      2'd3, '0);
    send_item(OP_UNREGISTER, '0,       10,      2'd0, '0);
    send_item(OP_REGISTER,   '0,       16,      2'd1, '0);
    send_item(OP_REGISTER,   '0,       16,      2'd2, '0);
    send_item(OP_LOOKUP,     '0,       '0,      2'd1, '0);
    send_item(OP_LOOKUP,     '0,       '0,      2'd2, 15);
    send_item(OP_LOOKUP,     '0,       '0,      2'd3, 16);
    send_item(OP_LOOKUP,     '0,       '0,      2'd0, 5);
    send_item(OP_REGISTER,   PAGE_TOP, END_TOP, 2'd3, '0);
    send_item(OP_LOOKUP,     '0,       '0,      2'd3, PAGE_TOP);
    send_item(OP_REGISTER,   20,       20,      2'd3, '0);
    send_item(OP_LOOKUP,     '0,       '0,      2'd3, 20);
    send_item(OP_REGISTER,   40,       30,      2'd1, '0);
    send_item(OP_REGISTER,   16,       24,      2'd0, '0);
    send_item(OP_LOOKUP,     '0,       '0,      2'd3, 17);
    send_item(OP_UNREGISTER, 4,        8,       2'd0, '0);
    send_item(OP_LOOKUP,     '0,       '0,      2'd3, 6);
    send_item(OP_LOOKUP,     '0,       '0,      2'd3, 9);
    send_item(OP_UNREGISTER, '0,       2,       2'd0, '0);
    send_item(OP_UNREGISTER, 12,       100,     2'd0, '0);
    send_item(OP_LOOKUP,     '0,       '0,      2'd3, 1);
    send_item(OP_UNREGISTER, '0,       END_TOP, 2'd0, '0);
    send_item(OP_LOOKUP,     '0,       '0,      2'd3, PAGE_TOP);
    send_item(OP_UNREGISTER, PAGE_TOP, END_TOP, 2'd0, '0);

    // Random: overlapping ranges in a 64-page window, base and op mix per phase
    base    = '0;
    reg_pct = 50;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        case ((n / PHASE_LEN) % 4)
          0:       base = '0;
          1:       base = PAGE_TOP - 63;
          default: base = rand_page();
        endcase
        if (base > PAGE_TOP - 63) base = PAGE_TOP - 63;
        reg_pct = ($urandom_range(0, 1) == 1) ? 70 : 40;
        quiet   = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < reg_pct)           op = OP_REGISTER;
      else if (pick < reg_pct + 25) op = OP_UNREGISTER;
      else                          op = OP_LOOKUP;
      m     = mode_t'($urandom_range(0, 3));
      shape = $urandom_range(0, 99);
      if (shape < 3) begin
        // noise across the whole page space
        s  = rand_page();
        e  = rand_end();
        pg = rand_page();
      end else if (shape < 5 && op == OP_UNREGISTER) begin
        // wipe the table now and then
        s  = '0;
        e  = END_TOP;
        pg = rand_page();
      end else begin
        s = base + page_t'($urandom_range(0, 63));
        if (shape < 10) e = {1'b0, base} + end_t'($urandom_range(0, 63));
        else            e = {1'b0, s} + end_t'($urandom_range(1, 16));
        if (e > END_TOP) e = END_TOP;
        pg = base + page_t'($urandom_range(0, 63));
      end
      send_item(op, s, e, m, pg);
    end

    s_axis_tvalid <= 1'b0;
    quiet = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4 * NUM_SLOTS) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== address_range_watch_table.f =====
rtl/arwt_pkg.sv
rtl/arwt_ctrl.sv
rtl/arwt_dp.sv
rtl/address_range_watch_table.sv
bench/arwt_check_pkg.sv
bench/address_range_watch_table_tb.sv
